FILE: rtl/sgn_pkg.sv
// ----------------------------------------------------------------------------
// sgn_pkg
// Types, constants and helpers shared by the softened gravity n-body stepper.
// ----------------------------------------------------------------------------
package sgn_pkg;

  localparam int MAX_BODIES = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  // divider width covers both m<<F and (S>>F)+5m
  localparam int DIV_W      = (64 - FRAC_BITS > 32 + FRAC_BITS) ? 64 - FRAC_BITS
                                                                 : 32 + FRAC_BITS;
  // unit vector components and acceleration stay at or below 2^F
  localparam int UQ_W       = FRAC_BITS + 1;
  localparam int PROD_W     = 2 * UQ_W;
  localparam int GMUL_W     = PROD_W + 8;
  localparam int TEN        = 10;
  // divide by ten: quotient bits per cycle and steps per divide
  localparam int D10_BITS   = 8;
  localparam int D10_STEPS  = (DIV_W + D10_BITS - 1) / D10_BITS;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        mass;
  } cmd_t;

  typedef struct packed {
    logic [4:0]         body_slot;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               last;
  } rpt_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        mass;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  // clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // clamp a position difference to +-(2^31-1)
  function automatic logic signed [31:0] sat_diff(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -33'sd2147483647) begin
      return 32'sh80000001;
    end
    return v[31:0];
  endfunction

  // magnitude of a signed word
  function automatic logic [31:0] vmag(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

endpackage

FILE: rtl/softened_gravity_nbody_step.sv
// ----------------------------------------------------------------------------
// softened_gravity_nbody_step
// 2D softened-gravity n-body stepper; bodies live in one RAM, a sequencer
// moves each body and sums the pull of every other valid body.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          beat
//  cmd      in   cmd_valid/stall    cmd_t: load, clear or tick
//  rpt      out  rpt_valid/stall    rpt_t: one body per beat after a tick
//  cfg      in   cfg_we             time multiplier, 8 bits
//
// Load, clear and an unused code finish without leaving idle. A tick walks all
// MAX_BODIES slots: each valid body moves by two divides by ten, then for each
// other valid body takes a root, three DIV_W-wide divides and two divides by
// ten; a coincident or massless partner skips that work.
// Then a scan sends one report per valid body.
// Reset clears valid bits, the multiplier (to 1) and the report valid.
// A stalled report holds the scan; a command waits while a tick runs.
module softened_gravity_nbody_step import sgn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  cmd_t       cmd,
  output logic       rpt_valid,
  input  logic       rpt_stall,
  output rpt_t       rpt,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [29:0] {
    S_IDLE   = 30'd1 << 0,
    S_RD_I   = 30'd1 << 1,
    S_LD_I   = 30'd1 << 2,
    S_PX     = 30'd1 << 3,
    S_PX_W   = 30'd1 << 4,
    S_PY     = 30'd1 << 5,
    S_PY_W   = 30'd1 << 6,
    S_RD_J   = 30'd1 << 7,
    S_LD_J   = 30'd1 << 8,
    S_SQX    = 30'd1 << 9,
    S_SQY    = 30'd1 << 10,
    S_RT     = 30'd1 << 11,
    S_RT_W   = 30'd1 << 12,
    S_DA     = 30'd1 << 13,
    S_DA_W   = 30'd1 << 14,
    S_DUX    = 30'd1 << 15,
    S_DUX_W  = 30'd1 << 16,
    S_DUY    = 30'd1 << 17,
    S_DUY_W  = 30'd1 << 18,
    S_GX     = 30'd1 << 19,
    S_GXD    = 30'd1 << 20,
    S_GXW    = 30'd1 << 21,
    S_GY     = 30'd1 << 22,
    S_GYD    = 30'd1 << 23,
    S_GYW    = 30'd1 << 24,
    S_NEXT_J = 30'd1 << 25,
    S_WB     = 30'd1 << 26,
    S_NEXT_I = 30'd1 << 27,
    S_O_SCAN = 30'd1 << 28,
    S_O_LD   = 30'd1 << 29
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BODIES - 1);

  state_t                  state;
  logic [MAX_BODIES-1:0]   vld;
  logic [7:0]              tmul;
  logic [IDX_W-1:0]        i;
  logic [IDX_W-1:0]        j;
  logic signed [31:0]      pix, piy, vix, viy;
  logic [30:0]             mi;
  logic signed [31:0]      dx, dy;
  logic [30:0]             ax, ay, mj;
  logic [62:0]             s;
  logic [31:0]             d;
  logic [UQ_W-1:0]         acc, ux, uy;
  logic [PROD_W-1:0]       prod;

  // memory ports
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  body_t                   ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [BODY_W-1:0]       ram_rdata;
  body_t                   rb;

  // shared units
  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_num, div_den, div_quo;
  logic                    d10_start, d10_done;
  logic [DIV_W-1:0]        d10_num, d10_quo;
  logic                    sq_done;
  logic [31:0]             sq_root;

  logic                    cmd_acc;
  logic                    slot_ok;
  logic signed [31:0]      dx_new, dy_new;
  logic [31:0]             adx_new, ady_new;
  logic signed [39:0]      qs;
  logic [39:0]             pnum_x, pnum_y;
  logic [GMUL_W-1:0]       gnum;
  logic                    more;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign slot_ok   = {27'd0, cmd.slot} < 32'(MAX_BODIES);
  assign rb        = body_t'(ram_rdata);

  sgn_ram #(.WIDTH(BODY_W), .DEPTH(MAX_BODIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sgn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  sgn_div10 u_div10 (
    .clk   (clk),
    .rst   (rst),
    .start (d10_start),
    .num   (d10_num),
    .done  (d10_done),
    .quo   (d10_quo)
  );

  sgn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_RT),
    .radicand ({1'b0, s}),
    .done     (sq_done),
    .root     (sq_root)
  );

  // datapath helpers
  always_comb begin
    dx_new  = sat_diff(33'(rb.px) - 33'(pix));
    dy_new  = sat_diff(33'(rb.py) - 33'(piy));
    adx_new = vmag(dx_new);
    ady_new = vmag(dy_new);
    qs      = signed'(40'(d10_quo[35:0]));
    pnum_x  = 40'(vmag(vix)) * 40'(tmul);
    pnum_y  = 40'(vmag(viy)) * 40'(tmul);
    gnum    = GMUL_W'(prod >> FRAC_BITS) * GMUL_W'(tmul);
    more    = 1'b0;
    for (int b = 0; b < MAX_BODIES; b++) begin
      if (IDX_W'(b) > i && vld[b]) begin
        more = 1'b1;
      end
    end
  end

  // memory port selection; write-backs never share a cycle with a pending read
  always_comb begin
    ram_raddr = (state == S_RD_J) ? j : i;
    ram_we    = 1'b0;
    ram_waddr = i;
    ram_wdata = '{px: pix, py: piy, vx: vix, vy: viy, mass: mi};
    if (state == S_WB) begin
      ram_we = 1'b1;
    end else if (cmd_acc && cmd.operation == OP_LOAD && slot_ok) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(cmd.slot);
      ram_wdata = '{px: cmd.pos_x, py: cmd.pos_y, vx: cmd.vel_x, vy: cmd.vel_y,
                    mass: cmd.mass};
    end
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_DA: begin
        div_start = 1'b1;
        div_num   = DIV_W'(64'(mj) << FRAC_BITS);
        div_den   = DIV_W'(s >> FRAC_BITS) + DIV_W'(34'(mj) * 34'd5);
      end
      S_DUX: begin
        div_start = 1'b1;
        div_num   = DIV_W'(64'(ax) << FRAC_BITS);
        div_den   = DIV_W'(d);
      end
      S_DUY: begin
        div_start = 1'b1;
        div_num   = DIV_W'(64'(ay) << FRAC_BITS);
        div_den   = DIV_W'(d);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // divide-by-ten operand selection
  always_comb begin
    d10_start = 1'b0;
    d10_num   = '0;
    case (state)
      S_PX: begin
        d10_start = 1'b1;
        d10_num   = DIV_W'(pnum_x);
      end
      S_PY: begin
        d10_start = 1'b1;
        d10_num   = DIV_W'(pnum_y);
      end
      S_GXD, S_GYD: begin
        d10_start = 1'b1;
        d10_num   = DIV_W'(gnum);
      end
      default: begin
        d10_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      tmul      <= 8'd1;
      rpt_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tmul <= cfg_wdata;
      end
      if (rpt_valid && !rpt_stall) begin
        rpt_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.operation)
              OP_LOAD: begin
                if (slot_ok) begin
                  vld[IDX_W'(cmd.slot)] <= 1'b1;
                end
              end
              OP_CLEAR: vld <= '0;
              OP_TICK: begin
                i     <= '0;
                state <= S_RD_I;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD_I: state <= vld[i] ? S_LD_I : S_NEXT_I;
        S_LD_I: begin
          pix   <= rb.px;
          piy   <= rb.py;
          vix   <= rb.vx;
          viy   <= rb.vy;
          mi    <= rb.mass;
          state <= S_PX;
        end
        S_PX: state <= S_PX_W;
        S_PX_W: begin
          if (d10_done) begin
            pix   <= sat32(40'(pix) + (vix[31] ? -qs : qs));
            state <= S_PY;
          end
        end
        S_PY: state <= S_PY_W;
        S_PY_W: begin
          if (d10_done) begin
            piy   <= sat32(40'(piy) + (viy[31] ? -qs : qs));
            j     <= '0;
            state <= S_RD_J;
          end
        end
        S_RD_J: state <= (j != i && vld[j]) ? S_LD_J : S_NEXT_J;
        // coincident or massless partner gives no change
        S_LD_J: begin
          dx    <= dx_new;
          dy    <= dy_new;
          ax    <= adx_new[30:0];
          ay    <= ady_new[30:0];
          mj    <= rb.mass;
          if ((dx_new == 0 && dy_new == 0) || rb.mass == 0) begin
            state <= S_NEXT_J;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX: begin
          s     <= 63'(62'(ax) * 62'(ax));
          state <= S_SQY;
        end
        S_SQY: begin
          s     <= s + 63'(62'(ay) * 62'(ay));
          state <= S_RT;
        end
        S_RT: state <= S_RT_W;
        S_RT_W: begin
          if (sq_done) begin
            d     <= sq_root;
            state <= S_DA;
          end
        end
        S_DA: state <= S_DA_W;
        S_DA_W: begin
          if (div_done) begin
            acc   <= div_quo[UQ_W-1:0];
            state <= S_DUX;
          end
        end
        S_DUX: state <= S_DUX_W;
        S_DUX_W: begin
          if (div_done) begin
            ux    <= div_quo[UQ_W-1:0];
            state <= S_DUY;
          end
        end
        S_DUY: state <= S_DUY_W;
        S_DUY_W: begin
          if (div_done) begin
            uy    <= div_quo[UQ_W-1:0];
            state <= S_GX;
          end
        end
        S_GX: begin
          prod  <= PROD_W'(ux) * PROD_W'(acc);
          state <= S_GXD;
        end
        S_GXD: state <= S_GXW;
        S_GXW: begin
          if (d10_done) begin
            vix   <= sat32(40'(vix) + (dx[31] ? -qs : qs));
            state <= S_GY;
          end
        end
        S_GY: begin
          prod  <= PROD_W'(uy) * PROD_W'(acc);
          state <= S_GYD;
        end
        S_GYD: state <= S_GYW;
        S_GYW: begin
          if (d10_done) begin
            viy   <= sat32(40'(viy) + (dy[31] ? -qs : qs));
            state <= S_NEXT_J;
          end
        end
        S_NEXT_J: begin
          if (j == LAST_IDX) begin
            state <= S_WB;
          end else begin
            j     <= j + 1'b1;
            state <= S_RD_J;
          end
        end
        S_WB: state <= S_NEXT_I;
        S_NEXT_I: begin
          if (i == LAST_IDX) begin
            i     <= '0;
            state <= S_O_SCAN;
          end else begin
            i     <= i + 1'b1;
            state <= S_RD_I;
          end
        end
        // report scan: read a valid slot only when the output register is free
        S_O_SCAN: begin
          if (vld[i]) begin
            if (!rpt_valid) begin
              state <= S_O_LD;
            end
          end else if (i == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_O_LD: begin
          rpt.body_slot <= 5'(i);
          rpt.new_pos_x <= rb.px;
          rpt.new_pos_y <= rb.py;
          rpt.new_vel_x <= rb.vx;
          rpt.new_vel_y <= rb.vy;
          rpt.last      <= !more;
          rpt_valid     <= 1'b1;
          if (i == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_O_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sgn_ram.sv
// ----------------------------------------------------------------------------
// sgn_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module sgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sgn_div.sv
// ----------------------------------------------------------------------------
// sgn_div
// Serial restoring divider, one quotient bit per cycle, truncating; and a
// divide-by-ten unit that settles D10_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module sgn_div import sgn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W:0]   rs;
  logic             qbit;

  // trial subtract of the shifted remainder
  always_comb begin
    rs   = {rem, quo[DIV_W-1]};
    qbit = (rs >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(DIV_W);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= qbit ? DIV_W'(rs - {1'b0, den_r}) : rs[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

module sgn_div10 import sgn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  localparam int D10_W = D10_STEPS * D10_BITS;
  localparam int CNT_W = $clog2(D10_STEPS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [3:0]          rem;
  logic [D10_W-1:0]    sh;
  logic [3:0]          rem_next;
  logic [D10_BITS-1:0] qd_next;

  assign quo = sh[DIV_W-1:0];

  // remainder stays below ten; one compare and subtract per dividend bit
  always_comb begin
    logic [4:0] t;
    rem_next = rem;
    qd_next  = '0;
    t        = '0;
    for (int b = 0; b < D10_BITS; b++) begin
      t = {rem_next, sh[D10_W-1-b]};
      if (t >= 5'(TEN)) begin
        qd_next[D10_BITS-1-b] = 1'b1;
        rem_next              = 4'(t - 5'(TEN));
      end else begin
        rem_next = t[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(D10_STEPS);
        rem  <= '0;
        sh   <= D10_W'(num);
      end else if (busy) begin
        rem <= rem_next;
        sh  <= {sh[D10_W-D10_BITS-1:0], qd_next};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/sgn_sqrt.sv
// ----------------------------------------------------------------------------
// sgn_sqrt
// Serial integer square root of a 64-bit word, one root bit per cycle.
// ----------------------------------------------------------------------------
module sgn_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] nn;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        nn   <= radicand;
        r    <= '0;
        bitv <= 64'd1 << 62;
      end else if (busy) begin
        if (nn >= trial) begin
          nn <= nn - trial;
          r  <= (r >> 1) + bitv;
        end else begin
          r  <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/sgn_checker.sv
// ----------------------------------------------------------------------------
// sgn_checker
// Watches the command, config and report channels of the n-body stepper,
// keeps its own copy of the body table, predicts every report beat of a tick
// and compares the reports in order, field by field.
// ----------------------------------------------------------------------------
module sgn_checker import sgn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_stall,
  input  cmd_t       cmd,
  input  logic       rpt_valid,
  input  logic       rpt_stall,
  input  rpt_t       rpt,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         fails,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_MAX  = 64'sd2147483647;
  localparam longint NEG_MIN  = -64'sd2147483648;

  // shadow body table and step multiplier
  longint          sh_px[MAX_BODIES];
  longint          sh_py[MAX_BODIES];
  longint          sh_vx[MAX_BODIES];
  longint          sh_vy[MAX_BODIES];
  longint unsigned sh_mass[MAX_BODIES];
  bit              sh_live[MAX_BODIES];
  longint unsigned mult;

  rpt_t report_q[$];

  function automatic longint clamp32(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < NEG_MIN) return NEG_MIN;
    return v;
  endfunction

  function automatic longint clamp_delta(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < -POS_MAX) return -POS_MAX;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // v times dt, truncated toward zero
  function automatic longint step_by_dt(longint v);
    longint unsigned m;
    m = (absval(v) * mult) / 10;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // velocity change of body i from the pull of body j
  function automatic void apply_pull(int i, int j);
    longint          dx, dy;
    longint unsigned ax, ay, s, d, m, den, a, ux, uy, gx, gy;
    dx = clamp_delta(sh_px[j] - sh_px[i]);
    dy = clamp_delta(sh_py[j] - sh_py[i]);
    ax = absval(dx);
    ay = absval(dy);
    if (ax == 0 && ay == 0) return;
    s   = ax * ax + ay * ay;
    d   = root_floor(s);
    m   = sh_mass[j];
    den = (s >> FRAC_BITS) + 5 * m;
    if (den == 0 || d == 0) return;
    a  = (m << FRAC_BITS) / den;
    ux = (ax << FRAC_BITS) / d;
    uy = (ay << FRAC_BITS) / d;
    gx = (((ux * a) >> FRAC_BITS) * mult) / 10;
    gy = (((uy * a) >> FRAC_BITS) * mult) / 10;
    sh_vx[i] = clamp32(sh_vx[i] + ((dx < 0) ? -longint'(gx) : longint'(gx)));
    sh_vy[i] = clamp32(sh_vy[i] + ((dy < 0) ? -longint'(gy) : longint'(gy)));
  endfunction

  // advance every live body and queue one report per body
  function automatic void run_tick();
    rpt_t r;
    int   lastk;
    for (int i = 0; i < MAX_BODIES; i++) begin
      if (!sh_live[i]) continue;
      sh_px[i] = clamp32(sh_px[i] + step_by_dt(sh_vx[i]));
      sh_py[i] = clamp32(sh_py[i] + step_by_dt(sh_vy[i]));
      for (int j = 0; j < MAX_BODIES; j++) begin
        if (j != i && sh_live[j]) apply_pull(i, j);
      end
    end
    lastk = -1;
    for (int i = 0; i < MAX_BODIES; i++) if (sh_live[i]) lastk = i;
    for (int i = 0; i < MAX_BODIES; i++) begin
      if (!sh_live[i]) continue;
      r.body_slot = i[4:0];
      r.new_pos_x = sh_px[i][31:0];
      r.new_pos_y = sh_py[i][31:0];
      r.new_vel_x = sh_vx[i][31:0];
      r.new_vel_y = sh_vy[i][31:0];
      r.last      = (i == lastk);
      report_q.push_back(r);
    end
  endfunction

  function automatic void note_bad(string what, longint e, longint g);
    fails++;
    if (fails <= 10)
      $display("%0t report %s mismatch: expected %0h, got %0h", $realtime, what, e, g);
  endfunction

  always @(posedge clk) begin
    rpt_t e;
    if (rst) begin
      for (int i = 0; i < MAX_BODIES; i++) sh_live[i] = 0;
      mult = 1;
      report_q.delete();
    end else begin
      if (cfg_we) mult = cfg_wdata;
      // command beat
      if (cmd_valid && !cmd_stall) begin
        case (cmd.operation)
          OP_LOAD: begin
            sh_px[cmd.slot]   = longint'(cmd.pos_x);
            sh_py[cmd.slot]   = longint'(cmd.pos_y);
            sh_vx[cmd.slot]   = longint'(cmd.vel_x);
            sh_vy[cmd.slot]   = longint'(cmd.vel_y);
            sh_mass[cmd.slot] = cmd.mass;
            sh_live[cmd.slot] = 1;
          end
          OP_CLEAR: for (int i = 0; i < MAX_BODIES; i++) sh_live[i] = 0;
          OP_TICK:  run_tick();
          default:  ;
        endcase
      end
      // report beat
      if (rpt_valid && !rpt_stall) begin
        if (report_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t unexpected report beat slot %0d", $realtime,
                                    rpt.body_slot);
        end else begin
          e = report_q.pop_front();
          if (rpt.body_slot !== e.body_slot) note_bad("slot", e.body_slot, rpt.body_slot);
          if (rpt.new_pos_x !== e.new_pos_x) note_bad("pos_x", e.new_pos_x, rpt.new_pos_x);
          if (rpt.new_pos_y !== e.new_pos_y) note_bad("pos_y", e.new_pos_y, rpt.new_pos_y);
          if (rpt.new_vel_x !== e.new_vel_x) note_bad("vel_x", e.new_vel_x, rpt.new_vel_x);
          if (rpt.new_vel_y !== e.new_vel_y) note_bad("vel_y", e.new_vel_y, rpt.new_vel_y);
          if (rpt.last !== e.last) note_bad("last", e.last, rpt.last);
        end
      end
    end
    pending = report_q.size();
  end

  initial begin
    fails   = 0;
    pending = 0;
    mult    = 1;
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the n-body stepper: directed extremes, then random
// load/tick sequences over several step multipliers, with random gaps on the
// command side and random stall on the report side.
// ----------------------------------------------------------------------------
module tb import sgn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3_000_000;

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  cmd_t       cmd;
  logic       rpt_valid;
  logic       rpt_stall;
  rpt_t       rpt;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fails;
  int         pending;
  int         quiet;
  int         stall_left;
  bit         no_stall;

  softened_gravity_nbody_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sgn_checker i_chk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // report side: random stall per beat, with stall-free stretches
  always @(posedge clk) begin
    if (rst) begin
      rpt_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) no_stall = !no_stall;
      if (rpt_valid && !rpt_stall) begin
        stall_left <= no_stall ? 0 : $urandom_range(0, 5);
        rpt_stall  <= 1'b0;
      end else if (stall_left > 0) begin
        rpt_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        rpt_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rpt_valid && !rpt_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(input cmd_t c);
    int g;
    g = no_stall ? 0 : $urandom_range(0, 5);
    if (g > 0) begin
      cmd_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
  endtask

  function automatic logic [31:0] near(int r);
    return 32'($signed($urandom_range(0, 2 * r)) - r);
  endfunction

  function automatic cmd_t load_of(int s, logic [31:0] px, logic [31:0] py,
                                   logic [31:0] vx, logic [31:0] vy, logic [30:0] m);
    cmd_t c;
    c.operation = OP_LOAD;
    c.slot = s[4:0];
    c.pos_x = px; c.pos_y = py; c.vel_x = vx; c.vel_y = vy; c.mass = m;
    return c;
  endfunction

  function automatic cmd_t op_of(logic [1:0] op);
    cmd_t c;
    c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    c.operation = op;
    return c;
  endfunction

  // body with random content: mostly close-range, sometimes raw bits
  function automatic cmd_t rand_body(int s);
    if ($urandom_range(0, 4) == 0)
      return load_of(s, $urandom, $urandom, $urandom, $urandom, 31'($urandom));
    return load_of(s, near(40 << 16), near(40 << 16), near(3 << 16), near(3 << 16),
                   31'($urandom_range(0, 30 << 16)));
  endfunction

  // quiet point for a register write: every report in, pipeline drained
  task automatic set_mult(input logic [7:0] v);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || cmd_stall) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int n;
    int sent;
    logic [7:0] mults[5];
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    rpt_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    quiet     = 0;
    no_stall  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tick, extremes with saturation, coincident and massless
    send(op_of(OP_TICK));
    send(load_of(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF));
    send(load_of(31, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF));
    send(op_of(OP_TICK));
    send(op_of(2'd3));
    send(load_of(5, 32'h00010000, 32'h00010000, '0, '0, 31'h00010000));
    send(load_of(6, 32'h00010000, 32'h00010000, '0, '0, 31'h00050000));
    send(load_of(7, 32'h00050000, 32'hFFFB0000, 32'h00008000, '0, '0));
    send(op_of(OP_TICK));
    send(op_of(OP_CLEAR));
    send(op_of(OP_TICK));
    set_mult(8'd0);
    send(load_of(1, 32'h00030000, '0, 32'h00010000, 32'hFFFF0000, 31'h00020000));
    send(load_of(2, '0, 32'h00040000, '0, '0, 31'h00020000));
    send(op_of(OP_TICK));
    set_mult(8'd255);
    send(op_of(OP_TICK));
    // one full table
    for (int s = 0; s < MAX_BODIES; s++) send(rand_body(s));
    send(op_of(OP_TICK));
    send(op_of(OP_CLEAR));

    // random phases over several step multipliers
    mults = '{8'd1, 8'd10, 8'd255, 8'd0, 8'($urandom_range(2, 254))};
    sent = 0;
    for (int p = 0; p < 5; p++) begin
      set_mult(mults[p]);
      while (sent < 52 * (p + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          send(op_of(2'($urandom_range(0, 3))));
          sent++;
        end else begin
          send(op_of(OP_CLEAR));
          n = $urandom_range(2, ($urandom_range(0, 7) == 0) ? 8 : 4);
          for (int k = 0; k < n; k++) send(rand_body($urandom_range(0, MAX_BODIES - 1)));
          repeat ($urandom_range(1, 3)) send(op_of(OP_TICK));
          sent += n + 3;
        end
      end
    end

    // drain
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sgn_pkg.sv
rtl/sgn_ram.sv
rtl/sgn_div.sv
rtl/sgn_sqrt.sv
rtl/softened_gravity_nbody_step.sv
tb/sv/sgn_checker.sv
tb/sv/tb.sv
